/* src/jsu_pkg.sv */
// jsu_pkg: shared types, character codes and the byte classifier of the
// JSON string unescaper. No dependencies; every other file but jsu_if imports it.
package jsu_pkg;

  // Character codes
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharU      = 8'h75;
  localparam logic [7:0] CharB      = 8'h62;
  localparam logic [7:0] CharF      = 8'h66;
  localparam logic [7:0] CharN      = 8'h6E;
  localparam logic [7:0] CharR      = 8'h72;
  localparam logic [7:0] CharT      = 8'h74;
  localparam logic [7:0] CharDig0   = 8'h30;
  localparam logic [7:0] CharDig9   = 8'h39;
  localparam logic [7:0] CharLowA   = 8'h61;
  localparam logic [7:0] CharLowF   = 8'h66;
  localparam logic [7:0] CharUpA    = 8'h41;
  localparam logic [7:0] CharUpF    = 8'h46;

  // Control bytes produced by escapes
  localparam logic [7:0] CtlBackspace = 8'h08;
  localparam logic [7:0] CtlFormFeed  = 8'h0C;
  localparam logic [7:0] CtlLineFeed  = 8'h0A;
  localparam logic [7:0] CtlCarriage  = 8'h0D;
  localparam logic [7:0] CtlTab       = 8'h09;

  // Largest \u value plus one that is decoded
  localparam logic [7:0] AsciiLimit = 8'h80;

  // Decoupling queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw    = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] data;      // raw byte
    logic [7:0] esc_data;  // byte to emit when this follows a backslash
    logic       is_bs;
    logic       is_u;
    logic       hex_ok;
    logic [3:0] hex_val;
  } jsu_item_t;

  typedef struct packed {
    jsu_item_t item;
    logic      last;
  } jsu_qitem_t;

  function automatic jsu_item_t jsu_classify(input logic [7:0] b);
    jsu_item_t r;
    r.data    = b;
    r.is_bs   = (b == CharBslash);
    r.is_u    = (b == CharU);
    r.hex_ok  = 1'b0;
    r.hex_val = 4'd0;
    if (b >= CharDig0 && b <= CharDig9) begin
      r.hex_ok  = 1'b1;
      r.hex_val = b[3:0];
    end else if ((b >= CharLowA && b <= CharLowF) || (b >= CharUpA && b <= CharUpF)) begin
      r.hex_ok  = 1'b1;
      r.hex_val = 4'(b[3:0] + 4'd9);
    end
    unique case (b)
      CharB:   r.esc_data = CtlBackspace;
      CharF:   r.esc_data = CtlFormFeed;
      CharN:   r.esc_data = CtlLineFeed;
      CharR:   r.esc_data = CtlCarriage;
      CharT:   r.esc_data = CtlTab;
      default: r.esc_data = b;
    endcase
    return r;
  endfunction

endpackage

/* src/jsu_if.sv */
// jsu_if: valid/ready stream interfaces for the escaped input bytes and
// the unescaped output bytes. No dependencies.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

/* src/jsu_front.sv */
// jsu_front: input register stage that accepts bytes and classifies them.
// Depends on jsu_pkg and jsu_in_if.
module jsu_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  jsu_in_if.sink              in_i,
  output logic                vld_o,
  output jsu_pkg::jsu_qitem_t item_o,
  input  logic                rdy_i
);
  import jsu_pkg::*;

  logic       vld_q, vld_d;
  jsu_qitem_t item_q;
  logic       take;

  assign in_i.ready = !vld_q || rdy_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (rdy_i) begin
      vld_d = 1'b0;
    end
    if (take) begin
      vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload: classify on capture
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.item <= jsu_classify(in_i.in_byte);
      item_q.last <= in_i.in_last;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

/* src/jsu_queue.sv */
// jsu_queue: short FIFO of classified bytes between front and back.
// Depends on jsu_pkg.
module jsu_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  jsu_pkg::jsu_qitem_t item_i,
  output logic                rdy_o,
  input  logic                pop_i,
  output logic                vld_o,
  output jsu_pkg::jsu_qitem_t item_o
);
  import jsu_pkg::*;

  jsu_qitem_t       mem_q [QDepth];
  logic [QAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCw-1:0]   cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign rdy_o   = (cnt_q != QCw'(QDepth));
  assign vld_o   = (cnt_q != '0);
  assign do_push = push_i && rdy_o;
  assign do_pop  = pop_i && vld_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QAw'(QDepth - 1)) ? '0 : QAw'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QAw'(QDepth - 1)) ? '0 : QAw'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = QCw'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = QCw'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCw'(QDepth))
    else $error("queue count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> (cnt_q == QCw'($past(cnt_q) - 1'b1)))
    else $error("queue count did not drop on pop");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with split pointers");

endmodule

/* src/jsu_back.sv */
// jsu_back: escape engine, hex collection buffer, replay sequencer and
// output register. Depends on jsu_pkg and jsu_out_if.
module jsu_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_vld_i,
  input  jsu_pkg::jsu_qitem_t q_item_i,
  output logic                q_pop_o,
  jsu_out_if.source           out_o
);
  import jsu_pkg::*;

  localparam logic [1:0] PhPlain = 2'd0;
  localparam logic [1:0] PhEsc   = 2'd1;
  localparam logic [1:0] PhHex   = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [1:0] hcnt_q, hcnt_d;
  jsu_item_t  hbuf_q [4];
  logic [2:0] rp_left_q, rp_left_d;
  logic [1:0] rp_pos_q, rp_pos_d;
  logic       rp_last_q, rp_last_d;
  logic       ovld_q, ovld_d;
  logic [7:0] obyte_q, obyte_d;
  logic       olast_q, olast_d;

  logic       rp_act, src_vld, src_last, adv;
  jsu_item_t  src;
  logic [7:0] hex_code;
  logic       hex_good;
  logic       emit, elast, hwr, ld_rp;
  logic [7:0] ebyte;
  logic [2:0] rp_n;

  // Replayed bytes take priority over the queue
  assign rp_act   = (rp_left_q != 3'd0);
  assign src      = rp_act ? hbuf_q[rp_pos_q] : q_item_i.item;
  assign src_last = rp_act ? (rp_last_q && rp_left_q == 3'd1) : q_item_i.last;
  assign src_vld  = rp_act || q_vld_i;
  assign adv      = src_vld && (!ovld_q || out_o.ready);
  assign q_pop_o  = adv && !rp_act;

  assign hex_code = {hbuf_q[2].hex_val, src.hex_val};
  assign hex_good = hbuf_q[0].hex_ok && hbuf_q[0].hex_val == 4'd0 &&
                    hbuf_q[1].hex_ok && hbuf_q[1].hex_val == 4'd0 &&
                    hbuf_q[2].hex_ok && src.hex_ok && hex_code < AsciiLimit;

  always_comb begin
    phase_d   = phase_q;
    hcnt_d    = hcnt_q;
    rp_left_d = rp_left_q;
    rp_pos_d  = rp_pos_q;
    rp_last_d = rp_last_q;
    emit      = 1'b0;
    ebyte     = src.data;
    elast     = src_last;
    hwr       = 1'b0;
    ld_rp     = 1'b0;
    rp_n      = 3'd0;
    if (adv) begin
      if (rp_act) begin
        rp_pos_d  = 2'(rp_pos_q + 1'b1);
        rp_left_d = 3'(rp_left_q - 1'b1);
      end
      unique case (phase_q)
        PhEsc: begin
          phase_d = PhPlain;
          if (src.is_u) begin
            if (src_last) begin
              emit  = 1'b1;
              ebyte = CharU;
            end else begin
              phase_d = PhHex;
              hcnt_d  = 2'd0;
            end
          end else begin
            emit  = 1'b1;
            ebyte = src.esc_data;
          end
        end
        PhHex: begin
          hwr    = 1'b1;
          hcnt_d = 2'(hcnt_q + 1'b1);
          if (hcnt_q == 2'd3) begin
            phase_d = PhPlain;
            hcnt_d  = 2'd0;
            emit    = 1'b1;
            if (hex_good) begin
              ebyte = hex_code;
            end else begin
              ebyte = CharU;
              elast = 1'b0;
              ld_rp = 1'b1;
              rp_n  = 3'd4;
            end
          end else if (src_last) begin
            phase_d = PhPlain;
            hcnt_d  = 2'd0;
            emit    = 1'b1;
            ebyte   = CharU;
            elast   = 1'b0;
            ld_rp   = 1'b1;
            rp_n    = 3'({1'b0, hcnt_q} + 3'd1);
          end
        end
        default: begin
          phase_d = PhPlain;
          if (src.is_bs && !src_last) begin
            phase_d = PhEsc;
          end else begin
            emit = 1'b1;
          end
        end
      endcase
      if (ld_rp) begin
        rp_left_d = rp_n;
        rp_pos_d  = 2'd0;
        rp_last_d = src_last;
      end
    end
  end

  always_comb begin
    ovld_d  = ovld_q;
    obyte_d = obyte_q;
    olast_d = olast_q;
    if (out_o.ready) begin
      ovld_d = 1'b0;
    end
    if (adv && emit) begin
      ovld_d  = 1'b1;
      obyte_d = ebyte;
      olast_d = elast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhPlain;
      hcnt_q    <= 2'd0;
      rp_left_q <= 3'd0;
      rp_pos_q  <= 2'd0;
      rp_last_q <= 1'b0;
      ovld_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      hcnt_q    <= hcnt_d;
      rp_left_q <= rp_left_d;
      rp_pos_q  <= rp_pos_d;
      rp_last_q <= rp_last_d;
      ovld_q    <= ovld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    olast_q <= olast_d;
    if (adv && hwr) begin
      hbuf_q[hcnt_q] <= src;
    end
  end

  assign out_o.valid    = ovld_q;
  assign out_o.out_byte = obyte_q;
  assign out_o.out_last = olast_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rp_left_q <= 3'd4)
    else $error("replay count above buffer size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rp_act |-> !q_pop_o)
    else $error("queue popped during replay");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hcnt_q != 2'd0) |-> (phase_q == PhHex))
    else $error("hex digits held outside hex phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && ld_rp) |-> (rp_left_q <= 3'd1))
    else $error("replay restarted with bytes still pending");

endmodule

/* src/json_string_unescaper.sv */
// json_string_unescaper: top level of the streaming JSON string unescaper.
// Depends on jsu_pkg, jsu_if, jsu_front, jsu_queue and jsu_back.
//
//   Channel | Direction | Payload             | Handshake
//   --------+-----------+---------------------+------------------
//   in_i    | in        | in_byte, in_last    | valid/ready
//   out_o   | out       | out_byte, out_last  | valid/ready
//
// One escaped byte enters per cycle and the back engine consumes one byte per
// cycle, so throughput is one byte per cycle while output is taken and no
// replay runs. A failed or cut-short \u escape replays up to four collected
// bytes through the single-byte engine in jsu_back, which pops no queue byte
// meanwhile; input keeps filling the front register and queue.
// The byte that completes a result passes the front register, the queue and
// the output register before output valid rises; a byte that opens an escape
// produces nothing on its own.
// Reset is asynchronous, active low, and returns the engine to plain text.
// Output stall holds the output register and backs up into the queue.
module json_string_unescaper (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);
  import jsu_pkg::*;

  // Front to queue
  logic       fr_vld, fr_rdy;
  jsu_qitem_t fr_item;

  // Queue to back
  logic       q_vld, q_pop;
  jsu_qitem_t q_item;

  // Accept and classify each input transaction
  jsu_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .vld_o  (fr_vld),
    .item_o (fr_item),
    .rdy_i  (fr_rdy)
  );

  // Decouple front and back so each can stall on its own
  jsu_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fr_vld),
    .item_i (fr_item),
    .rdy_o  (fr_rdy),
    .pop_i  (q_pop),
    .vld_o  (q_vld),
    .item_o (q_item)
  );

  // Run the escape engine, replay failed \u bytes, hold the result
  jsu_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_vld_i  (q_vld),
    .q_item_i (q_item),
    .q_pop_o  (q_pop),
    .out_o    (out_o)
  );

endmodule
